/* sv/ifa_pkg.sv */
// Package for the interleaved frame averager: constants and shared types.
`timescale 1ns / 1ps
package ifa_pkg;
  localparam int DEF_MAX_SLOTS        = 8;
  localparam int DEF_MAX_FRAME_PIXELS = 4096;
  localparam int PIX_W  = 16;
  localparam int PASS_W = 16;
  localparam int SLOT_W = 3;
  localparam int BS_W   = 4;
  localparam int FP_W   = 13;
  localparam int CFG_W  = 13;
  localparam logic [PASS_W-1:0] PASS_MAX = '1;

  typedef enum logic {
    REG_BLOCK_SIZE   = 1'b0,
    REG_FRAME_PIXELS = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_OUT
  } state_t;

  // Request to the divider: numerator and divisor.
  typedef struct packed {
    logic [PIX_W+PASS_W-1:0] num;
    logic [PASS_W:0]         den;
  } div_req_t;
endpackage

/* sv/ifa_ram.sv */
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module ifa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

/* sv/ifa_div.sv */
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module ifa_div
  import ifa_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  div_req_t          req,
  output logic              done,
  output logic [PIX_W-1:0]  quot
);
  localparam int NW = PIX_W + PASS_W;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0]   num;
  logic [PASS_W:0] den;
  logic [PASS_W+1:0] rem;
  logic [NW-1:0]   q;
  logic [CW-1:0]   cnt;
  logic            busy;
  logic [PASS_W+1:0] trial;
  logic [PASS_W+1:0] diff;

  assign trial = {rem[PASS_W:0], num[NW-1]};
  assign diff  = trial - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= req.num;
      den <= req.den;
      rem <= '0;
      q   <= '0;
    end else if (busy) begin
      num <= {num[NW-2:0], 1'b0};
      if (!diff[PASS_W+1]) begin
        rem <= diff;
        q   <= {q[NW-2:0], 1'b1};
      end else begin
        rem <= trial;
        q   <= {q[NW-2:0], 1'b0};
      end
    end
  end

  // mean never exceeds the largest pixel
  assign quot = q[PIX_W-1:0];

  assert property (@(posedge clk) disable iff (rst) start |=> busy);
  assert property (@(posedge clk) disable iff (rst) done |-> !busy);
endmodule

/* sv/interleaved_frame_averager.sv */
// Interleaved running frame average: top level with counters and control.
`timescale 1ns / 1ps
// Pixels stream in raster order; frames go round-robin into block_size slots
// held in one RAM addressed by slot and pixel position. Pass 0 stores, later
// passes write floor((pass*old+new)/(pass+1)). A pixel takes one RAM read,
// then on averaging passes a bit-serial divide; a store pass steps through
// accept and write, an averaging pass through accept, divider start, the
// divide steps and write. One pixel is in work at a time; a new pixel is
// taken only while the result register is empty or being read. A
// configuration write restarts all counters.
module interleaved_frame_averager
  import ifa_pkg::*;
#(
  parameter int MAX_SLOTS        = DEF_MAX_SLOTS,
  parameter int MAX_FRAME_PIXELS = DEF_MAX_FRAME_PIXELS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [15:0]      s_tdata,   // [15:0] pixel_value
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [39:0]      m_tdata,   // [15:0] averaged_value, [18:16] slot,
                                      // [34:19] pass_number, rest zero
  output logic             m_tlast,   // frame_end
  output logic             m_tuser    // block_complete
);
  localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int PW = (MAX_FRAME_PIXELS > 1) ? $clog2(MAX_FRAME_PIXELS) : 1;
  localparam int AW = SW + PW;
  localparam int NW = PIX_W + PASS_W;

  logic [BS_W-1:0] block_size;
  logic [FP_W-1:0] frame_pixels;
  logic [PW:0]     fp_eff;
  logic [SW:0]     bs_eff;
  logic [PW:0]     pos;
  logic [SW:0]     slot;
  logic [PASS_W-1:0] pass_count;
  state_t state, state_next;
  logic [PIX_W-1:0] pix;
  logic [PIX_W-1:0] rdata, wval;
  logic we;
  logic div_start, div_done;
  logic [PIX_W-1:0] quot;
  div_req_t req;
  logic fend, bdone;
  logic [PW:0] pos_inc;
  logic [SW:0] slot_inc;

  always_comb begin
    if (block_size == '0) bs_eff = (SW+1)'(1);
    else if ({28'd0, block_size} > 32'(MAX_SLOTS)) bs_eff = (SW+1)'(MAX_SLOTS);
    else bs_eff = (SW+1)'(block_size);
    if (frame_pixels == '0) fp_eff = (PW+1)'(1);
    else if ({19'd0, frame_pixels} > 32'(MAX_FRAME_PIXELS))
      fp_eff = (PW+1)'(MAX_FRAME_PIXELS);
    else fp_eff = (PW+1)'(frame_pixels);
  end

  ifa_ram #(.WIDTH(PIX_W), .DEPTH(1 << AW)) u_ram (
    .clk(clk), .we(we), .addr({slot[SW-1:0], pos[PW-1:0]}),
    .wdata(wval), .rdata(rdata)
  );

  assign req = '{
    num: NW'(pass_count) * NW'(rdata) + NW'(pix),
    den: {1'b0, pass_count} + (PASS_W+1)'(1)
  };

  ifa_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .req(req),
    .done(div_done), .quot(quot)
  );

  assign pos_inc  = pos + 1'b1;
  assign slot_inc = slot + 1'b1;
  assign fend  = (pos_inc >= fp_eff);
  assign bdone = fend && (slot_inc >= bs_eff);

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    div_start  = 1'b0;
    we         = 1'b0;
    wval       = quot;
    case (state)
      ST_IDLE: begin
        s_tready = !m_tvalid || m_tready;
        if (s_tvalid && s_tready) state_next = ST_READ;
      end
      ST_READ: begin
        if (pass_count == '0) begin
          we = 1'b1;
          wval = pix;
          state_next = ST_IDLE;
        end else begin
          div_start = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          we = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_size   <= BS_W'(1);
      frame_pixels <= FP_W'(4096);
      pos <= '0; slot <= '0; pass_count <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (state == ST_IDLE && s_tvalid && s_tready) begin
        pix <= s_tdata;
        if (pos >= fp_eff) pos <= '0;
        if (slot >= bs_eff) slot <= '0;
      end
      if (we) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {5'd0, pass_count, 3'(slot), wval};
        m_tlast  <= fend;
        m_tuser  <= bdone;
        pos <= fend ? '0 : pos_inc;
        if (fend) slot <= bdone ? '0 : slot_inc;
        if (bdone && pass_count != PASS_MAX) pass_count <= pass_count + 1'b1;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_BLOCK_SIZE:   block_size   <= cfg_wdata[BS_W-1:0];
          REG_FRAME_PIXELS: frame_pixels <= cfg_wdata[FP_W-1:0];
          default: ;
        endcase
        pos <= '0; slot <= '0; pass_count <= '0;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) we |=> m_tvalid);
  assert property (@(posedge clk) disable iff (rst) m_tuser && m_tvalid |-> m_tlast);
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> pass_count != '0);
endmodule

/* tb/interleaved_frame_averager_test.sv */
// Testbench for the interleaved frame averager: predicted running means checked per word.
`timescale 1ns / 1ps
module interleaved_frame_averager_test;
  import ifa_pkg::*;

  typedef struct {
    logic [PIX_W-1:0]  avg;
    logic [SLOT_W-1:0] slot;
    logic [PASS_W-1:0] pass;
    logic              fend;
    logic              bdone;
  } pixel_mean_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_we;
  logic             cfg_index;
  logic [CFG_W-1:0] cfg_wdata;
  logic             s_tvalid;
  logic             s_tready;
  logic [15:0]      s_tdata;   // [15:0] pixel_value
  logic             m_tvalid;
  logic             m_tready;
  logic [39:0]      m_tdata;   // [15:0] averaged_value, [18:16] slot, [34:19] pass_number
  logic             m_tlast;   // frame_end
  logic             m_tuser;   // block_complete

  interleaved_frame_averager dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state
  logic [PIX_W-1:0]  mean_store [DEF_MAX_SLOTS*DEF_MAX_FRAME_PIXELS];
  int unsigned       pos_ctr, slot_ctr, pass_ctr;
  logic [BS_W-1:0]   blk_size;
  logic [FP_W-1:0]   frm_pixels;

  pixel_mean_t pending_means[$];
  int          fail_count;
  int          hold_len;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  function automatic pixel_mean_t predict_mean(input logic [PIX_W-1:0] pix);
    pixel_mean_t r;
    int unsigned bs, fp, pos, slot, addr;
    longint unsigned num;
    bs = (blk_size == 0) ? 1 : (blk_size > DEF_MAX_SLOTS) ? DEF_MAX_SLOTS : blk_size;
    fp = (frm_pixels == 0) ? 1 :
         (frm_pixels > DEF_MAX_FRAME_PIXELS) ? DEF_MAX_FRAME_PIXELS : frm_pixels;
    pos = (pos_ctr >= fp) ? 0 : pos_ctr;
    slot = (slot_ctr >= bs) ? 0 : slot_ctr;
    addr = slot * DEF_MAX_FRAME_PIXELS + pos;
    if (pass_ctr == 0) begin
      r.avg = pix;
    end else begin
      num = longint'(pass_ctr) * mean_store[addr] + pix;
      r.avg = PIX_W'(num / (pass_ctr + 1));
    end
    mean_store[addr] = r.avg;
    r.slot = SLOT_W'(slot);
    r.pass = PASS_W'(pass_ctr);
    r.fend = 1'b0;
    r.bdone = 1'b0;
    pos++;
    if (pos >= fp) begin
      r.fend = 1'b1;
      pos = 0;
      slot++;
      if (slot >= bs) begin
        slot = 0;
        r.bdone = 1'b1;
        if (pass_ctr < PASS_MAX) pass_ctr++;
      end
    end
    pos_ctr = pos;
    slot_ctr = slot;
    return r;
  endfunction

  task automatic send_pixel(input logic [15:0] pix, input int gap);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pix;
    do @(posedge clk); while (!s_tready);
    pending_means.push_back(predict_mean(pix));
  endtask

  task automatic wait_drain();
    s_tvalid <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
    wait_drain();
    repeat (40) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_BLOCK_SIZE) blk_size = val[BS_W-1:0];
    else frm_pixels = val[FP_W-1:0];
    pos_ctr = 0;
    slot_ctr = 0;
    pass_ctr = 0;
  endtask

  function automatic logic [15:0] rand_pixel();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Result side: random stalls, optional long hold, compare each word.
  initial begin
    pixel_mean_t want;
    int n;
    m_tready <= 1'b0;
    @(negedge rst);
    forever begin
      n = $urandom_range(10);
      if (hold_len > 0) begin
        n = hold_len;
        hold_len = 0;
      end
      if (n > 0) begin
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      if (pending_means.size() == 0) begin
        report_mismatch("unexpected word", m_tdata, 0);
      end else begin
        want = pending_means.pop_front();
        if (m_tdata[15:0] !== want.avg) report_mismatch("averaged_value", m_tdata[15:0], want.avg);
        if (m_tdata[18:16] !== want.slot) report_mismatch("slot", m_tdata[18:16], want.slot);
        if (m_tdata[34:19] !== want.pass) report_mismatch("pass_number", m_tdata[34:19], want.pass);
        if (m_tdata[39:35] !== 5'd0) report_mismatch("tdata padding", m_tdata[39:35], 0);
        if (m_tlast !== want.fend) report_mismatch("frame_end", m_tlast, want.fend);
        if (m_tuser !== want.bdone) report_mismatch("block_complete", m_tuser, want.bdone);
      end
    end
  end

  task automatic test_reset_defaults();
    // block size 1, 4096-pixel frames: a few pixels, then restart
    for (int i = 0; i < 4; i++) send_pixel(rand_pixel(), $urandom_range(10));
  endtask

  task automatic test_small_block();
    write_reg(REG_FRAME_PIXELS, 13'd2);
    write_reg(REG_BLOCK_SIZE, 13'd3);
    for (int i = 0; i < 18; i++) begin
      // hold the result side while pixels keep coming
      if (i == 2) hold_len = 300;
      send_pixel((i % 3 == 0) ? 16'hFFFF : (i % 3 == 1) ? 16'h0000 : 16'($urandom),
                 $urandom_range(10));
    end
  endtask

  task automatic test_clamped_sizes();
    write_reg(REG_BLOCK_SIZE, 13'd0);
    write_reg(REG_FRAME_PIXELS, 13'd0);
    for (int i = 0; i < 3; i++) send_pixel(rand_pixel(), $urandom_range(10));
    write_reg(REG_BLOCK_SIZE, 13'd15);
    write_reg(REG_FRAME_PIXELS, 13'd8191);
    for (int i = 0; i < 3; i++) send_pixel(rand_pixel(), $urandom_range(10));
  endtask

  task automatic test_random_streams();
    int total, count, bs, fp;
    total = 0;
    while (total < 1400) begin
      case ($urandom_range(5))
        0: bs = 1;
        1: bs = 8;
        default: bs = $urandom_range(1, 8);
      endcase
      case ($urandom_range(9))
        0: fp = 1;
        1: fp = $urandom_range(32, 96);
        default: fp = $urandom_range(1, 12);
      endcase
      write_reg(REG_BLOCK_SIZE, 13'(bs));
      write_reg(REG_FRAME_PIXELS, 13'(fp));
      count = bs * fp * $urandom_range(2, 5);
      if (count > 300) count = 300;
      for (int i = 0; i < count; i++) begin
        if (i == 5 && total < 200) hold_len = 300;
        if (i == count / 2 && $urandom_range(3) == 0) wait_drain();
        // runs with no gaps now and then
        send_pixel(rand_pixel(), (i % 40 < 10) ? 0 : $urandom_range(10));
      end
      total += count;
    end
  endtask

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_BLOCK_SIZE;
    cfg_wdata <= '0;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    fail_count = 0;
    hold_len = 0;
    blk_size = 4'd1;
    frm_pixels = 13'd4096;
    pos_ctr = 0;
    slot_ctr = 0;
    pass_ctr = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_small_block();
    test_clamped_sizes();
    test_random_streams();
    wait_drain();
    repeat (60) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end
endmodule

/* interleaved_frame_averager.f */
sv/ifa_pkg.sv
sv/ifa_ram.sv
sv/ifa_div.sv
sv/interleaved_frame_averager.sv
tb/interleaved_frame_averager_test.sv
